FILE: sv/dpls_pkg.sv
// Package for the distance paced line steering unit.
// Holds the register reset values, speed and steering caps and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpls_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE            = 3'd0;
    localparam logic [2:0] REG_TARGET_POSITION = 3'd1;
    localparam logic [2:0] REG_TARGET_DISTANCE = 3'd2;
    localparam logic [2:0] REG_TOP_SPEED       = 3'd3;
    localparam logic [2:0] REG_BASE_SPEED      = 3'd4;
    localparam logic [2:0] REG_GAIN            = 3'd5;
    localparam logic [2:0] REG_RANGE_CLAMP     = 3'd6;
    localparam logic [2:0] REG_STOP_DISTANCE   = 3'd7;

    // Operating modes.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_LATCH = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [1:0]  RST_MODE            = 2'd0;
    localparam logic [9:0]  RST_TARGET_POSITION = 10'd120;
    localparam logic [9:0]  RST_TARGET_DISTANCE = 10'd320;
    localparam logic [13:0] RST_TOP_SPEED       = 14'd3200;
    localparam logic [13:0] RST_BASE_SPEED      = 14'd0;
    localparam logic [5:0]  RST_GAIN            = 6'd12;
    localparam logic [11:0] RST_RANGE_CLAMP     = 12'd400;
    localparam logic [11:0] RST_STOP_DISTANCE   = 12'd100;

    // Upper caps on the speed (quotient plus base speed) and on the steering term.
    localparam logic signed [28:0] CAP_SPEED_M0  = 29'sd3400;
    localparam logic signed [28:0] CAP_SPEED_M1  = 29'sd5500;
    localparam logic signed [28:0] CAP_SPEED_M2  = 29'sd7000;
    localparam logic signed [17:0] CAP_STEER_M0  = 18'sd1000;
    localparam logic signed [17:0] CAP_STEER_M12 = 18'sd4000;

    // Divider geometry: the product magnitude fits in 27 bits.
    localparam int unsigned DVD_W = 27;
    localparam logic [4:0]  DIV_LAST = 5'(DVD_W - 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: sv/distance_paced_line_steering_unit.sv
// Top level of the distance paced line steering unit.
// Uses dpls_pkg for register defaults, caps and sequencer states.
// Contains the config registers, one multiply step and a serial divider.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    line_position, range_sample,
//                                             run_enable, straight_override
// out       output     out_valid / out_ready  left_speed, right_speed, stopped
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One item occupies the sequencer from acceptance until its result is loaded:
// the accepting cycle captures and clamps, then a multiply step, the restoring
// divider by target_distance and a final step to cap, steer and saturate. The
// next item is taken only after that, as in_ready is high only while the sequencer
// idles. A finished result waits in the output register; the sequencer holds
// its last step while the output register is full and out_ready is low.
// Reset clears control state and the track latch.

module distance_paced_line_steering_unit
    import dpls_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [9:0]         line_position,
    input  wire logic [11:0]        range_sample,
    input  wire logic               run_enable,
    input  wire logic               straight_override,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      left_speed,
    output logic signed [15:0]      right_speed,
    output logic                    stopped,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [13:0]        cfg_data
);

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [9:0]  target_position_reg;
    logic [9:0]  target_distance_reg;
    logic [13:0] top_speed_reg;
    logic [13:0] base_speed_reg;
    logic [5:0]  gain_reg;
    logic [11:0] range_clamp_reg;
    logic [11:0] stop_distance_reg;

    // Sequencer and per-item state.
    state_t      state_reg, state_next;
    logic        track_latch_reg;
    logic [11:0] r_reg;
    logic [9:0]  line_reg;
    logic [9:0]  div_reg;
    logic [13:0] base_eff_reg;
    logic        stop_reg;
    logic        straight_reg;
    logic        neg_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [9:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic signed [17:0] steer_reg;

    // Output register.
    logic               out_valid_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic               stopped_reg;

    logic in_fire;
    logic out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign stopped     = stopped_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= RST_MODE;
            target_position_reg <= RST_TARGET_POSITION;
            target_distance_reg <= RST_TARGET_DISTANCE;
            top_speed_reg       <= RST_TOP_SPEED;
            base_speed_reg      <= RST_BASE_SPEED;
            gain_reg            <= RST_GAIN;
            range_clamp_reg     <= RST_RANGE_CLAMP;
            stop_distance_reg   <= RST_STOP_DISTANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:            mode_reg            <= cfg_data[1:0];
                REG_TARGET_POSITION: target_position_reg <= cfg_data[9:0];
                REG_TARGET_DISTANCE: target_distance_reg <= cfg_data[9:0];
                REG_TOP_SPEED:       top_speed_reg       <= cfg_data;
                REG_BASE_SPEED:      base_speed_reg      <= cfg_data;
                REG_GAIN:            gain_reg            <= cfg_data[5:0];
                REG_RANGE_CLAMP:     range_clamp_reg     <= cfg_data[11:0];
                REG_STOP_DISTANCE:   stop_distance_reg   <= cfg_data[11:0];
                default:             ;
            endcase
        end
    end

    // Range clamp, latch update and stop decision at acceptance.
    logic        latched_mode;
    logic [11:0] lim;
    logic [11:0] r_in;
    logic        latch_set;
    logic        stop_in;

    always_comb
    begin
        latched_mode = (mode_reg != MODE_PLAIN);
        lim = (latched_mode && track_latch_reg) ? {2'b00, target_distance_reg}
                                                : range_clamp_reg;
        r_in = (range_sample > lim) ? lim : range_sample;
        latch_set = latched_mode && (r_in < {2'b00, target_distance_reg});
        stop_in = !run_enable || (r_in < stop_distance_reg);
    end

    // Multiply step: scaled range product and steering product.
    logic signed [14:0] speed_diff;
    logic signed [27:0] prod;
    logic signed [10:0] pos_err;
    logic signed [17:0] steer_prod;
    logic [27:0]        prod_mag;

    always_comb
    begin
        speed_diff = signed'({1'b0, top_speed_reg}) - signed'({1'b0, base_eff_reg});
        prod       = signed'({16'd0, r_reg}) * 28'(speed_diff);
        prod_mag   = prod[27] ? 28'(-prod) : 28'(prod);
        pos_err    = signed'({1'b0, target_position_reg}) - signed'({1'b0, line_reg});
        steer_prod = signed'({12'd0, gain_reg}) * 18'(pos_err);
    end

    // One restoring divider step.
    logic [10:0] rem_shift;
    logic        q_bit;
    logic [10:0] rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        q_bit     = (rem_shift >= {1'b0, div_reg});
    end

    // Final step: sign, offset, caps, saturation and the stop and straight selections.
    logic signed [28:0] quot;
    logic signed [28:0] speed;
    logic signed [28:0] cap_speed;
    logic signed [17:0] cap_steer;
    logic signed [17:0] steer;
    logic signed [29:0] sum_l;
    logic signed [29:0] sum_r;
    logic signed [15:0] left_fin;
    logic signed [15:0] right_fin;

    function automatic logic signed [15:0] sat16(input logic signed [29:0] v);
        logic signed [15:0] res;
        begin
            if (v > 30'sd32767)
                res = 16'sh7FFF;
            else if (v < -30'sd32768)
                res = 16'sh8000;
            else
                res = v[15:0];
            return res;
        end
    endfunction

    always_comb
    begin
        quot  = neg_reg ? -signed'({2'b00, dvd_reg}) : signed'({2'b00, dvd_reg});
        speed = quot + signed'({15'd0, base_eff_reg});
        if (mode_reg == MODE_PLAIN)
            cap_speed = CAP_SPEED_M0;
        else if (mode_reg == MODE_LATCH)
            cap_speed = CAP_SPEED_M1;
        else
            cap_speed = CAP_SPEED_M2;
        cap_steer = (mode_reg == MODE_PLAIN) ? CAP_STEER_M0 : CAP_STEER_M12;
        if (speed > cap_speed)
            speed = cap_speed;
        steer = (steer_reg > cap_steer) ? cap_steer : steer_reg;
        sum_l = 30'(speed) + 30'(steer);
        sum_r = 30'(speed) - 30'(steer);
        if (stop_reg)
        begin
            left_fin  = '0;
            right_fin = '0;
        end
        else if (straight_reg)
        begin
            left_fin  = signed'({2'b00, top_speed_reg});
            right_fin = signed'({2'b00, top_speed_reg});
        end
        else
        begin
            left_fin  = sat16(sum_l);
            right_fin = sat16(sum_r);
        end
    end

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == DIV_LAST) state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            track_latch_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && latch_set)
                track_latch_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_MUL)
                cnt_reg <= '0;
            else if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            r_reg        <= r_in;
            line_reg     <= line_position;
            div_reg      <= (target_distance_reg == 10'd0) ? 10'd1 : target_distance_reg;
            base_eff_reg <= (mode_reg == MODE_PLAIN) ? 14'd0 : base_speed_reg;
            stop_reg     <= stop_in;
            straight_reg <= mode_reg[1] && straight_override;
        end
        if (state_reg == ST_MUL)
        begin
            neg_reg   <= prod[27];
            dvd_reg   <= prod_mag[DVD_W-1:0];
            rem_reg   <= '0;
            steer_reg <= steer_prod;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= q_bit ? rem_sub[9:0] : rem_shift[9:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
        end
        if (out_load)
        begin
            left_reg    <= left_fin;
            right_reg   <= right_fin;
            stopped_reg <= stop_reg;
        end
    end

endmodule

`default_nettype wire
